// ===== hdl/per_sensor_mean_stddev_accumulator_core_defines.svh =====
// Assertion macros used by the checker file of the accumulator core.
`ifndef PER_SENSOR_MEAN_STDDEV_ACCUMULATOR_CORE_DEFINES_SVH
`define PER_SENSOR_MEAN_STDDEV_ACCUMULATOR_CORE_DEFINES_SVH

// Condition in one cycle implies a consequence in the same cycle.
`define PSMSA_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define PSMSA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/psmsa_pkg.sv =====
// Shared types and constants of the per-sensor statistics accumulator.
`default_nettype none

package psmsa_pkg;

    localparam int SENSOR_W  = 10;
    localparam int CNT_W     = 16;
    localparam int SUM_W     = 48;
    localparam int SQ_W      = 64;
    localparam int ENERGY_W  = 48;
    localparam int ALERT_W   = 32;
    localparam int MUL_W     = 32;
    localparam int DIV_STEPS = 64;

    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_QUERY    = 2'd1;
    localparam logic [1:0] OP_SCAN     = 2'd2;
    localparam logic [1:0] KIND_TEMP   = 2'd0;
    localparam logic [1:0] KIND_ENERGY = 2'd1;

    // One row of the per-sensor table.
    typedef struct packed {
        logic                    active;
        logic [CNT_W-1:0]        count;
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sumsq;
    } entry_t;

    typedef enum logic [2:0] {
        CTL_CLEAR,
        CTL_IDLE,
        CTL_REC,
        CTL_QRD,
        CTL_QSTAT,
        CTL_SRD,
        CTL_SCHK,
        CTL_SSTAT
    } ctl_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV1,
        ST_DIV2,
        ST_MUL,
        ST_SUB,
        ST_SQRT,
        ST_DONE
    } stat_state_t;

endpackage

`default_nettype wire

// ===== hdl/per_sensor_mean_stddev_accumulator_core.sv =====
// A record keeps busy high while its row is written back; the next one waits for idle.
// A query reads its row and, for a sensor with samples, runs the statistics unit
// (two 64-step divisions, 32-step root) before done. A scan visits every sensor through
// the one table read port. Results last one cycle; the receiver cannot stall.
// After reset the table is cleared one row a cycle, with busy high until the last row.
`default_nettype none

module per_sensor_mean_stddev_accumulator_core #(
    parameter int NUM_SENSORS = 1024,
    parameter int VALUE_WIDTH = 24
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [1:0]                             op,
    input  logic [psmsa_pkg::SENSOR_W-1:0]         sensor,
    input  logic [1:0]                             kind,
    input  logic signed [VALUE_WIDTH-1:0]          value,
    input  logic                                   alert,
    output logic                                   busy,
    output logic                                   done,
    output logic [psmsa_pkg::SENSOR_W-1:0]         sensor_index,
    output logic                                   found,
    output logic [psmsa_pkg::CNT_W-1:0]            sample_count,
    output logic signed [VALUE_WIDTH-1:0]          mean,
    output logic [VALUE_WIDTH-2:0]                 std_dev,
    output logic signed [psmsa_pkg::ENERGY_W-1:0]  energy_total,
    output logic [psmsa_pkg::ALERT_W-1:0]          alert_total
);
    import psmsa_pkg::*;

    localparam int AW = $clog2(NUM_SENSORS);
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_SENSORS - 1);
    localparam logic signed [ENERGY_W-1:0] ENERGY_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
    localparam logic signed [ENERGY_W-1:0] ENERGY_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

    ctl_state_t state_reg, state_next;

    logic [AW-1:0]                clr_reg;
    logic [AW-1:0]                scan_reg;
    logic [SENSOR_W-1:0]          sensor_reg;
    logic                         in_range_reg;
    logic [1:0]                   kind_reg;
    logic signed [VALUE_WIDTH-1:0] value_reg;
    logic signed [ENERGY_W-1:0]   energy_reg;
    logic [ALERT_W-1:0]           alert_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         done_reg;
    logic [SENSOR_W-1:0]          sensor_index_reg;
    logic                         found_reg;
    logic [CNT_W-1:0]             sample_count_reg;
    logic signed [VALUE_WIDTH-1:0] mean_reg;
    logic [VALUE_WIDTH-2:0]       std_dev_reg;

    logic                         best_found_reg, best_found_next;
    logic [AW-1:0]                best_idx_reg, best_idx_next;
    logic [CNT_W-1:0]             best_cnt_reg, best_cnt_next;
    logic signed [VALUE_WIDTH-1:0] best_mean_reg, best_mean_next;
    logic [VALUE_WIDTH-2:0]       best_std_reg, best_std_next;

    logic [16:0]                  sensor_wide;
    logic [AW-1:0]                sensor_addr;
    logic                         in_range;
    logic [16:0]                  sensor_reg_wide;
    logic [AW-1:0]                sensor_reg_addr;

    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    entry_t                       wr_data;
    logic [AW-1:0]                rd_addr;
    entry_t                       rd_data;
    entry_t                       upd_entry;

    logic                         ent_ok;
    logic                         stat_start;
    logic                         stat_done;
    logic signed [VALUE_WIDTH-1:0] stat_mean;
    logic [VALUE_WIDTH-2:0]       stat_std;
    logic                         scan_last;
    logic                         scan_step;
    logic                         take_best;

    logic                         emit;
    logic [SENSOR_W-1:0]          emit_idx;
    logic                         emit_found;
    logic [CNT_W-1:0]             emit_cnt;
    logic signed [VALUE_WIDTH-1:0] emit_mean;
    logic [VALUE_WIDTH-2:0]       emit_std;

    logic [VALUE_WIDTH:0]         v_ext;
    logic [VALUE_WIDTH:0]         v_abs;
    logic [VALUE_WIDTH-1:0]       v_mag;
    logic [2*VALUE_WIDTH-1:0]     v_sq;
    logic [ENERGY_W:0]            e_sum;
    logic signed [ENERGY_W-1:0]   e_sat;
    logic                         take_rec;

    // Address decode of the incoming and the held sensor index.
    assign sensor_wide     = 17'(sensor);
    assign sensor_addr     = sensor_wide[AW-1:0];
    assign in_range        = sensor_wide < 17'(NUM_SENSORS);
    assign sensor_reg_wide = 17'(sensor_reg);
    assign sensor_reg_addr = sensor_reg_wide[AW-1:0];

    psmsa_ram #(
        .DEPTH(NUM_SENSORS),
        .AW   (AW)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    psmsa_stats #(
        .VW(VALUE_WIDTH)
    ) u_stats (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (stat_start),
        .sum    (rd_data.sum),
        .sumsq  (rd_data.sumsq),
        .count  (rd_data.count),
        .done   (stat_done),
        .mean   (stat_mean),
        .std_dev(stat_std)
    );

    // Record update of the row read in the previous cycle.
    assign v_ext = (VALUE_WIDTH+1)'(value_reg);
    assign v_abs = value_reg[VALUE_WIDTH-1] ? -v_ext : v_ext;
    assign v_mag = v_abs[VALUE_WIDTH-1:0];
    assign v_sq  = v_mag * v_mag;

    always_comb
    begin
        upd_entry        = rd_data;
        upd_entry.active = 1'b1;
        if (kind_reg == KIND_TEMP && rd_data.count != '1)
        begin
            upd_entry.count = rd_data.count + CNT_W'(1);
            upd_entry.sum   = rd_data.sum + SUM_W'(value_reg);
            upd_entry.sumsq = rd_data.sumsq + SQ_W'(v_sq);
        end
    end

    // Saturating energy sum.
    assign e_sum = {energy_reg[ENERGY_W-1], energy_reg} + (ENERGY_W+1)'(value);
    always_comb
    begin
        if (e_sum[ENERGY_W] != e_sum[ENERGY_W-1])
        begin
            e_sat = e_sum[ENERGY_W] ? ENERGY_MIN : ENERGY_MAX;
        end
        else
        begin
            e_sat = e_sum[ENERGY_W-1:0];
        end
    end

    assign take_rec  = start && state_reg == CTL_IDLE && op == OP_ADD && in_range;
    assign ent_ok    = rd_data.active && rd_data.count != '0;
    assign scan_last = scan_reg == LAST_IDX;
    assign take_best = !best_found_reg || stat_std > best_std_reg;

    // Table port selection.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = sensor_reg_addr;
        wr_data = upd_entry;
        rd_addr = sensor_reg_addr;
        unique case (state_reg)
            CTL_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
            end
            CTL_IDLE: rd_addr = sensor_addr;
            CTL_REC:  wr_en = 1'b1;
            CTL_SRD:  rd_addr = scan_reg;
            default:
            begin
            end
        endcase
    end

    // Best candidate of a scan, including the sensor finishing this cycle.
    always_comb
    begin
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_cnt_next   = best_cnt_reg;
        best_mean_next  = best_mean_reg;
        best_std_next   = best_std_reg;
        if (state_reg == CTL_SSTAT && stat_done && take_best)
        begin
            best_found_next = 1'b1;
            best_idx_next   = scan_reg;
            best_cnt_next   = cnt_reg;
            best_mean_next  = stat_mean;
            best_std_next   = stat_std;
        end
    end

    // Control sequencer: next state, stats start, scan advance and result word.
    always_comb
    begin
        state_next = state_reg;
        stat_start = 1'b0;
        scan_step  = 1'b0;
        emit       = 1'b0;
        emit_idx   = sensor_reg;
        emit_found = 1'b0;
        emit_cnt   = '0;
        emit_mean  = '0;
        emit_std   = '0;
        unique case (state_reg)
            CTL_CLEAR:
            begin
                if (clr_reg == LAST_IDX)
                begin
                    state_next = CTL_IDLE;
                end
            end
            CTL_IDLE:
            begin
                if (start)
                begin
                    priority case (op)
                        OP_ADD:
                        begin
                            if (in_range)
                            begin
                                state_next = CTL_REC;
                            end
                        end
                        OP_QUERY: state_next = CTL_QRD;
                        OP_SCAN:  state_next = CTL_SRD;
                        default:  state_next = CTL_IDLE;
                    endcase
                end
            end
            CTL_REC: state_next = CTL_IDLE;
            CTL_QRD:
            begin
                if (in_range_reg && ent_ok)
                begin
                    stat_start = 1'b1;
                    state_next = CTL_QSTAT;
                end
                else
                begin
                    emit       = 1'b1;
                    emit_cnt   = in_range_reg ? rd_data.count : '0;
                    state_next = CTL_IDLE;
                end
            end
            CTL_QSTAT:
            begin
                if (stat_done)
                begin
                    emit       = 1'b1;
                    emit_found = 1'b1;
                    emit_cnt   = cnt_reg;
                    emit_mean  = stat_mean;
                    emit_std   = stat_std;
                    state_next = CTL_IDLE;
                end
            end
            CTL_SRD: state_next = CTL_SCHK;
            CTL_SCHK:
            begin
                if (ent_ok)
                begin
                    stat_start = 1'b1;
                    state_next = CTL_SSTAT;
                end
                else if (scan_last)
                begin
                    emit       = 1'b1;
                    state_next = CTL_IDLE;
                end
                else
                begin
                    scan_step  = 1'b1;
                    state_next = CTL_SRD;
                end
            end
            CTL_SSTAT:
            begin
                if (stat_done)
                begin
                    if (scan_last)
                    begin
                        emit       = 1'b1;
                        state_next = CTL_IDLE;
                    end
                    else
                    begin
                        scan_step  = 1'b1;
                        state_next = CTL_SRD;
                    end
                end
            end
            default: state_next = CTL_IDLE;
        endcase
        // A scan reports its best candidate.
        if (emit && (state_reg == CTL_SCHK || state_reg == CTL_SSTAT))
        begin
            emit_idx   = SENSOR_W'(best_idx_next);
            emit_found = best_found_next;
            emit_cnt   = best_cnt_next;
            emit_mean  = best_mean_next;
            emit_std   = best_std_next;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= CTL_CLEAR;
            clr_reg        <= '0;
            scan_reg       <= '0;
            energy_reg     <= '0;
            alert_reg      <= '0;
            done_reg       <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= emit;
            if (state_reg == CTL_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (take_rec && kind == KIND_ENERGY)
            begin
                energy_reg <= e_sat;
            end
            if (take_rec && alert && alert_reg != '1)
            begin
                alert_reg <= alert_reg + ALERT_W'(1);
            end
            if (state_reg == CTL_IDLE && start && op == OP_SCAN)
            begin
                scan_reg       <= '0;
                best_found_reg <= 1'b0;
            end
            else
            begin
                if (scan_step)
                begin
                    scan_reg <= scan_reg + AW'(1);
                end
                best_found_reg <= best_found_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == CTL_IDLE && start)
        begin
            sensor_reg    <= sensor;
            in_range_reg  <= in_range;
            kind_reg      <= kind;
            value_reg     <= value;
            best_idx_reg  <= '0;
            best_cnt_reg  <= '0;
            best_mean_reg <= '0;
            best_std_reg  <= '0;
        end
        else
        begin
            best_idx_reg  <= best_idx_next;
            best_cnt_reg  <= best_cnt_next;
            best_mean_reg <= best_mean_next;
            best_std_reg  <= best_std_next;
        end
        if (stat_start)
        begin
            cnt_reg <= rd_data.count;
        end
        if (emit)
        begin
            sensor_index_reg <= emit_idx;
            found_reg        <= emit_found;
            sample_count_reg <= emit_cnt;
            mean_reg         <= emit_mean;
            std_dev_reg      <= emit_std;
        end
    end

    assign busy         = state_reg != CTL_IDLE;
    assign done         = done_reg;
    assign sensor_index = sensor_index_reg;
    assign found        = found_reg;
    assign sample_count = sample_count_reg;
    assign mean         = mean_reg;
    assign std_dev      = std_dev_reg;
    assign energy_total = energy_reg;
    assign alert_total  = alert_reg;

endmodule

`default_nettype wire

// ===== hdl/psmsa_ram.sv =====
// Per-sensor table: one write port and one registered read port.
`default_nettype none

module psmsa_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  psmsa_pkg::entry_t wr_data,
    input  logic [AW-1:0]    rd_addr,
    output psmsa_pkg::entry_t rd_data
);
    import psmsa_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hdl/psmsa_stats.sv =====
// Sequential mean and standard deviation unit: shared divider, one multiply, bitwise root.
`default_nettype none

module psmsa_stats #(
    parameter int VW = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [psmsa_pkg::SUM_W-1:0] sum,
    input  logic [psmsa_pkg::SQ_W-1:0]         sumsq,
    input  logic [psmsa_pkg::CNT_W-1:0]        count,
    output logic                               done,
    output logic signed [VW-1:0]               mean,
    output logic [VW-2:0]                      std_dev
);
    import psmsa_pkg::*;

    localparam logic [SQ_W-1:0] STD_MAX = (SQ_W'(1) << (VW - 1)) - SQ_W'(1);

    stat_state_t state_reg, state_next;

    logic              neg_reg;
    logic [CNT_W-1:0]  den_reg;
    logic [SQ_W-1:0]   dvd_reg;
    logic [CNT_W:0]    rem_reg;
    logic [5:0]        step_reg;
    logic [SQ_W-1:0]   q_reg;
    logic [SQ_W-1:0]   sumsq_reg;
    logic [SQ_W-1:0]   msq_reg;
    logic [SQ_W-1:0]   x_reg;
    logic [SQ_W-1:0]   res_reg;
    logic [SQ_W-1:0]   bit_reg;

    logic [SUM_W-1:0]  sum_abs;
    logic [CNT_W:0]    rem_sh;
    logic              div_ge;
    logic [CNT_W:0]    rem_new;
    logic [SQ_W-1:0]   dvd_new;
    logic              div_last;
    logic [SQ_W-1:0]   root_try;
    logic [VW-1:0]     q_low;

    // One restoring division step per cycle.
    assign sum_abs  = sum[SUM_W-1] ? -sum : sum;
    assign rem_sh   = {rem_reg[CNT_W-1:0], dvd_reg[SQ_W-1]};
    assign div_ge   = rem_sh >= {1'b0, den_reg};
    assign rem_new  = div_ge ? rem_sh - {1'b0, den_reg} : rem_sh;
    assign dvd_new  = {dvd_reg[SQ_W-2:0], div_ge};
    assign div_last = step_reg == 6'(DIV_STEPS - 1);
    assign root_try = res_reg + bit_reg;

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: rounded mean, mean square, square of mean, difference, root.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                if (div_last)
                begin
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                if (div_last)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_SUB;
            ST_SUB:  state_next = ST_SQRT;
            ST_SQRT:
            begin
                if (bit_reg == SQ_W'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    neg_reg   <= sum[SUM_W-1];
                    den_reg   <= count;
                    dvd_reg   <= SQ_W'(sum_abs) + SQ_W'(count >> 1);
                    rem_reg   <= '0;
                    step_reg  <= '0;
                    sumsq_reg <= sumsq;
                end
            end
            ST_DIV1:
            begin
                step_reg <= step_reg + 6'd1;
                if (div_last)
                begin
                    q_reg   <= dvd_new;
                    dvd_reg <= sumsq_reg;
                    rem_reg <= '0;
                end
                else
                begin
                    dvd_reg <= dvd_new;
                    rem_reg <= rem_new;
                end
            end
            ST_DIV2:
            begin
                step_reg <= step_reg + 6'd1;
                dvd_reg  <= dvd_new;
                rem_reg  <= rem_new;
                if (div_last)
                begin
                    x_reg <= dvd_new;
                end
            end
            ST_MUL:
            begin
                msq_reg <= SQ_W'(q_reg[MUL_W-1:0] * q_reg[MUL_W-1:0]);
            end
            ST_SUB:
            begin
                x_reg   <= (x_reg > msq_reg) ? x_reg - msq_reg : '0;
                res_reg <= '0;
                bit_reg <= SQ_W'(1) << (SQ_W - 2);
            end
            ST_SQRT:
            begin
                if (x_reg >= root_try)
                begin
                    x_reg   <= x_reg - root_try;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            default:
            begin
            end
        endcase
    end

    // Results, valid while the sequencer sits in its final state.
    assign q_low   = q_reg[VW-1:0];
    assign done    = state_reg == ST_DONE;
    assign mean    = neg_reg ? $signed(-q_low) : $signed(q_low);
    assign std_dev = (res_reg > STD_MAX) ? STD_MAX[VW-2:0] : res_reg[VW-2:0];

endmodule

`default_nettype wire

// ===== hdl/psmsa_checker.sv =====
// Port-level checker of the accumulator core and its bind.
`default_nettype none
`include "per_sensor_mean_stddev_accumulator_core_defines.svh"

module psmsa_checker #(
    parameter int VALUE_WIDTH = 24
) (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   start,
    input logic [1:0]                             op,
    input logic [psmsa_pkg::SENSOR_W-1:0]         sensor,
    input logic [1:0]                             kind,
    input logic signed [VALUE_WIDTH-1:0]          value,
    input logic                                   alert,
    input logic                                   busy,
    input logic                                   done,
    input logic [psmsa_pkg::SENSOR_W-1:0]         sensor_index,
    input logic                                   found,
    input logic [psmsa_pkg::CNT_W-1:0]            sample_count,
    input logic signed [VALUE_WIDTH-1:0]          mean,
    input logic [VALUE_WIDTH-2:0]                 std_dev,
    input logic signed [psmsa_pkg::ENERGY_W-1:0]  energy_total,
    input logic [psmsa_pkg::ALERT_W-1:0]          alert_total
);
    import psmsa_pkg::*;

    // A result word only appears once the block is free again.
    `PSMSA_ASSERT_SAME(a_done_not_busy, clk, rst_n, done, !busy, "result while busy")
    // A record never produces a result word.
    `PSMSA_ASSERT_NEXT(a_rec_silent, clk, rst_n, start && !busy && op == OP_ADD, !done, "record gave result")
    // Results are single-cycle pulses.
    `PSMSA_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "result repeated")
    // A miss reports zero statistics.
    `PSMSA_ASSERT_SAME(a_miss_zero, clk, rst_n, done && !found, mean == '0 && std_dev == '0, "miss with stats")

endmodule

bind per_sensor_mean_stddev_accumulator_core psmsa_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
) u_psmsa_checker (.*);

`default_nettype wire
